@@ rtl/pidc_pkg.sv @@
// Shared types for the duplicate packet id cache.
package pidc_pkg;

    // Requested operation
    typedef enum logic [1:0] {
        ACT_PUT  = 2'd0,
        ACT_GET  = 2'd1,
        ACT_SET  = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // Query held steady for the whole walk down the chain
    typedef struct packed {
        t_action     action;
        logic [23:0] key;
        logic [31:0] now;
    } t_query;

    // Result gathered as the token passes the cells
    typedef struct packed {
        logic        found;
        logic        ovalid;
        logic [7:0]  conn;
        logic [31:0] sent_ms;
    } t_acc;

    // Ring write issued at the end of a put miss
    typedef struct packed {
        logic        en;
        logic [23:0] key;
        logic [7:0]  conn;
    } t_write;

endpackage

@@ rtl/pidc_cell.sv @@
// One cache entry: key compare, held handle, send time, token hand-on.
module pidc_cell #(
    parameter int SLOT_W = 10,
    parameter int INDEX  = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pidc_pkg::t_query i_query,
    input  pidc_pkg::t_write i_write,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic            i_tok,
    input  pidc_pkg::t_acc  i_acc,
    output logic            o_tok,
    output pidc_pkg::t_acc  o_acc
);

    logic        r_valid;
    logic [23:0] r_key;
    logic        r_held;
    logic [7:0]  r_conn;
    logic [31:0] r_time;
    logic        r_tok;
    pidc_pkg::t_acc r_acc;
    pidc_pkg::t_acc n_acc;
    logic        hit;
    logic        wr_here;

    assign hit     = i_tok && r_valid && (r_key == i_query.key);
    assign wr_here = i_write.en && (i_slot == SLOT_W'(INDEX));

    // Merge this entry into the passing result word
    always_comb begin
        n_acc = i_acc;
        if (hit) begin
            n_acc.found = 1'b1;
            if (i_query.action == pidc_pkg::ACT_GET && r_held) begin
                n_acc.ovalid  = 1'b1;
                n_acc.conn    = r_conn;
                n_acc.sent_ms = r_time;
            end
        end
    end

    // Control: valid bit and token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= 1'b0;
        end else begin
            r_tok <= i_tok;
            if (wr_here) begin
                r_valid <= 1'b1;
            end
        end
    end

    // Entry payload and result register
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (wr_here) begin
            r_key  <= i_write.key;
            r_held <= 1'b1;
            r_conn <= i_write.conn;
            r_time <= 32'd0;
        end else if (hit) begin
            if (i_query.action == pidc_pkg::ACT_GET) begin
                r_held <= 1'b0;
            end else if (i_query.action == pidc_pkg::ACT_SET) begin
                r_time <= i_query.now;
            end
        end
    end

    assign o_tok = r_tok;
    assign o_acc = r_acc;

endmodule

@@ rtl/packet_id_dedup_cache.sv @@
// Top level of the duplicate packet id cache: controller and cell chain.
// Usage:
//   Drive start high with action, dest_node, packet_id, conn_handle and
//   now_ms; the word is taken at a clock edge where busy is low.
//   A token then walks the chain of ENTRIES cells, one cell per cycle; each
//   cell compares its key and, on a match, serves get origin (returns and
//   releases the handle) or set timestamp.
//   After the last cell the result word is shown for one cycle with
//   o_strobe high; a put that missed writes the ring slot at that same edge
//   and advances the ring pointer.
//   No new word is taken while a token walks the chain; busy is low again
//   in the strobe cycle.
//   Action 3 leaves the table alone and returns all-zero fields.
//   Reset (synchronous, active low) clears every valid bit, the ring
//   pointer and the controller; no clearing pass is needed.
//   The receiver cannot stall: each result must be taken in its cycle.
module packet_id_dedup_cache #(
    parameter int ENTRIES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_dest_node,
    input  logic [15:0] i_packet_id,
    input  logic [7:0]  i_conn_handle,
    input  logic [31:0] i_now_ms,
    output logic        o_strobe,
    output logic        o_key_found,
    output logic        o_origin_valid,
    output logic [7:0]  o_origin_conn,
    output logic [31:0] o_time_sent
);

    localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    pidc_pkg::t_state r_state, n_state;
    pidc_pkg::t_query r_query;
    logic [7:0]       r_conn_in;
    logic [SLOT_W-1:0] r_slot;
    logic             r_tok;
    logic             r_strobe;
    pidc_pkg::t_acc   r_out;
    pidc_pkg::t_write wr;
    logic             accept;
    logic             tail_tok;
    pidc_pkg::t_acc   tail_acc;

    logic           tok [ENTRIES+1];
    pidc_pkg::t_acc acc [ENTRIES+1];

    assign accept   = start && (r_state == pidc_pkg::ST_IDLE);
    assign busy     = (r_state == pidc_pkg::ST_RUN);
    assign tail_tok = tok[ENTRIES];
    assign tail_acc = acc[ENTRIES];

    // Ring write on a put miss, at the end of the walk
    always_comb begin
        wr.en   = tail_tok && (r_query.action == pidc_pkg::ACT_PUT) && !tail_acc.found;
        wr.key  = r_query.key;
        wr.conn = r_conn_in;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pidc_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = pidc_pkg::ST_RUN;
                end
            end
            pidc_pkg::ST_RUN: begin
                if (tail_tok) begin
                    n_state = pidc_pkg::ST_IDLE;
                end
            end
            default: n_state = pidc_pkg::ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pidc_pkg::ST_IDLE;
            r_tok    <= 1'b0;
            r_strobe <= 1'b0;
            r_slot   <= '0;
        end else begin
            r_state  <= n_state;
            r_tok    <= accept;
            r_strobe <= tail_tok;
            if (wr.en) begin
                if (r_slot == SLOT_W'(ENTRIES - 1)) begin
                    r_slot <= '0;
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
            end
        end
    end

    // Query capture and result word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_query.action <= pidc_pkg::t_action'(i_action);
            r_query.key    <= {i_dest_node, i_packet_id};
            r_query.now    <= i_now_ms;
            r_conn_in      <= i_conn_handle;
        end
        if (tail_tok) begin
            if (r_query.action == pidc_pkg::ACT_NONE) begin
                r_out <= '0;
            end else begin
                r_out <= tail_acc;
            end
        end
    end

    // Cell chain
    assign tok[0] = r_tok;
    assign acc[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        pidc_cell #(
            .SLOT_W(SLOT_W),
            .INDEX (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_query(r_query),
            .i_write(wr),
            .i_slot (r_slot),
            .i_tok  (tok[g]),
            .i_acc  (acc[g]),
            .o_tok  (tok[g+1]),
            .o_acc  (acc[g+1])
        );
    end

    assign o_strobe       = r_strobe;
    assign o_key_found    = r_out.found;
    assign o_origin_valid = r_out.ovalid;
    assign o_origin_conn  = r_out.conn;
    assign o_time_sent    = r_out.sent_ms;

    // Checks
    a_strobe_after_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(tail_tok)) else $error("strobe without tail token");
    a_tail_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tail_tok |-> (r_state == pidc_pkg::ST_RUN)) else $error("token outside walk");
    a_origin_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_origin_valid) |-> o_key_found) else $error("origin without key");
    a_origin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_origin_valid) |-> (o_origin_conn == 8'd0 && o_time_sent == 32'd0))
        else $error("origin fields not zero");

endmodule

@@ tb/packet_id_dedup_cache_tb.sv @@
// Self-checking testbench for the duplicate packet id cache: directed table, then random traffic.
module packet_id_dedup_cache_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 1024;
    localparam int N_RANDOM = 1600;

    // Short names for the action codes
    localparam pidc_pkg::t_action A_PUT  = pidc_pkg::ACT_PUT;
    localparam pidc_pkg::t_action A_GET  = pidc_pkg::ACT_GET;
    localparam pidc_pkg::t_action A_SET  = pidc_pkg::ACT_SET;
    localparam pidc_pkg::t_action A_NONE = pidc_pkg::ACT_NONE;

    // Result word as seen on the outputs
    typedef struct {
        logic        found;
        logic        ovalid;
        logic [7:0]  conn;
        logic [31:0] tsent;
    } t_lookup;

    // One row of the directed table
    typedef struct {
        pidc_pkg::t_action act;
        logic [7:0]  dest;
        logic [15:0] id;
        logic [7:0]  conn;
        logic [31:0] now;
        bit          typed;
        t_lookup     res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_action;
    logic [7:0]  i_dest_node;
    logic [15:0] i_packet_id;
    logic [7:0]  i_conn_handle;
    logic [31:0] i_now_ms;
    logic        o_strobe;
    logic        o_key_found;
    logic        o_origin_valid;
    logic [7:0]  o_origin_conn;
    logic [31:0] o_time_sent;

    // Shadow copy of the table
    bit          sh_valid [SLOTS];
    logic [23:0] sh_key   [SLOTS];
    logic        sh_held  [SLOTS];
    logic [7:0]  sh_conn  [SLOTS];
    logic [31:0] sh_time  [SLOTS];
    int          sh_wptr;

    t_lookup     pending_q [$];
    logic [23:0] seen_keys [$];
    int          n_errors;
    t_row        rows [$];

    packet_id_dedup_cache dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_dest_node    (i_dest_node),
        .i_packet_id    (i_packet_id),
        .i_conn_handle  (i_conn_handle),
        .i_now_ms       (i_now_ms),
        .o_strobe       (o_strobe),
        .o_key_found    (o_key_found),
        .o_origin_valid (o_origin_valid),
        .o_origin_conn  (o_origin_conn),
        .o_time_sent    (o_time_sent)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        n_errors++;
    endtask

    // Apply one word to the shadow table and return the lookup it yields
    function automatic t_lookup cache_lookup(input pidc_pkg::t_action act,
                                             input logic [23:0] key,
                                             input logic [7:0] conn, input logic [31:0] now);
        t_lookup r;
        int hit;
        r = '{1'b0, 1'b0, 8'h00, 32'h0};
        hit = -1;
        if (act == A_NONE) return r;
        for (int i = 0; i < SLOTS; i++)
            if (sh_valid[i] && sh_key[i] == key) hit = i;
        r.found = (hit >= 0);
        case (act)
            A_PUT: begin
                if (hit < 0) begin
                    sh_valid[sh_wptr] = 1'b1;
                    sh_key[sh_wptr]   = key;
                    sh_held[sh_wptr]  = 1'b1;
                    sh_conn[sh_wptr]  = conn;
                    sh_time[sh_wptr]  = '0;
                    sh_wptr = (sh_wptr + 1) % SLOTS;
                end
            end
            A_GET: begin
                if (hit >= 0 && sh_held[hit]) begin
                    r.ovalid = 1'b1;
                    r.conn   = sh_conn[hit];
                    r.tsent  = sh_time[hit];
                    sh_held[hit] = 1'b0;
                end
            end
            default: begin
                if (hit >= 0) sh_time[hit] = now;
            end
        endcase
        return r;
    endfunction

    // Offer one word, hold it until taken, then queue its expected result
    task automatic send_word(input t_row w);
        t_lookup pred;
        int gap;
        i_action      <= w.act;
        i_dest_node   <= w.dest;
        i_packet_id   <= w.id;
        i_conn_handle <= w.conn;
        i_now_ms      <= w.now;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy);
        pred = cache_lookup(w.act, {w.dest, w.id}, w.conn, w.now);
        pending_q.push_back(w.typed ? w.res : pred);
        if (w.act == A_PUT) seen_keys.push_back({w.dest, w.id});
        // idle gap: usually none or short, now and then long
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Compare each strobed word with the oldest expectation
    always @(posedge i_clk) begin
        t_lookup e;
        if (i_rst_n && o_strobe) begin
            if (pending_q.size() == 0) begin
                $display("%0t unexpected result word", $realtime);
                n_errors++;
            end else begin
                e = pending_q.pop_front();
                if (o_key_found !== e.found)    report("key_found", o_key_found, e.found);
                if (o_origin_valid !== e.ovalid) report("origin_valid", o_origin_valid, e.ovalid);
                if (o_origin_conn !== e.conn)   report("origin_conn", o_origin_conn, e.conn);
                if (o_time_sent !== e.tsent)    report("sent time", o_time_sent, e.tsent);
            end
        end
    end

    function automatic t_row mk(input pidc_pkg::t_action a, input logic [7:0] d,
                                input logic [15:0] id,
                                input logic [7:0] c, input logic [31:0] n, input bit typed,
                                input logic f, input logic v, input logic [7:0] oc,
                                input logic [31:0] ot);
        t_row r;
        r.act = a; r.dest = d; r.id = id; r.conn = c; r.now = n;
        r.typed = typed;
        r.res = '{f, v, oc, ot};
        return r;
    endfunction

    initial begin
        t_row w;
        int sel;
        n_errors = 0;
        sh_wptr = 0;
        foreach (sh_valid[i]) sh_valid[i] = 1'b0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_action <= A_NONE;
        i_dest_node <= '0;
        i_packet_id <= '0;
        i_conn_handle <= '0;
        i_now_ms <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, extremes, each action, ignored action
        rows.push_back(mk(A_GET,  8'hFF, 16'hFFFF, 8'h00, 32'h0,        1, 0, 0, 8'h00, 32'h0));
        rows.push_back(mk(A_SET,  8'hFF, 16'hFFFF, 8'h00, 32'hFFFFFFFF, 1, 0, 0, 8'h00, 32'h0));
        rows.push_back(mk(A_NONE, 8'hFF, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, 1, 0, 0, 8'h00, 32'h0));
        rows.push_back(mk(A_PUT,  8'hFF, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, 1, 0, 0, 8'h00, 32'h0));
        rows.push_back(mk(A_PUT,  8'hFF, 16'hFFFF, 8'h11, 32'h0,        1, 1, 0, 8'h00, 32'h0));
        rows.push_back(mk(A_GET,  8'hFF, 16'hFFFF, 8'h00, 32'h0,        1, 1, 1, 8'hFF, 32'h0));
        rows.push_back(mk(A_GET,  8'hFF, 16'hFFFF, 8'h00, 32'h0,        1, 1, 0, 8'h00, 32'h0));
        rows.push_back(mk(A_PUT,  8'h00, 16'h0000, 8'h00, 32'h0,        1, 0, 0, 8'h00, 32'h0));
        rows.push_back(mk(A_SET,  8'h00, 16'h0000, 8'hFF, 32'hFFFFFFFF, 1, 1, 0, 8'h00, 32'h0));
        rows.push_back(mk(A_NONE, 8'h00, 16'h0000, 8'h00, 32'h0,        1, 0, 0, 8'h00, 32'h0));
        rows.push_back(mk(A_GET,  8'h00, 16'h0000, 8'h00, 32'h0,        1, 1, 1, 8'h00,
                          32'hFFFFFFFF));
        // same id, other destination: a different key
        rows.push_back(mk(A_PUT,  8'h00, 16'hFFFF, 8'hA5, 32'h0,        1, 0, 0, 8'h00, 32'h0));
        rows.push_back(mk(A_PUT,  8'hFF, 16'h0000, 8'h5A, 32'h0,        1, 0, 0, 8'h00, 32'h0));
        rows.push_back(mk(A_SET,  8'h00, 16'hFFFF, 8'h00, 32'h12345678, 0, 0, 0, 8'h00, 32'h0));
        rows.push_back(mk(A_SET,  8'h00, 16'hFFFF, 8'h00, 32'h00000001, 0, 0, 0, 8'h00, 32'h0));
        rows.push_back(mk(A_GET,  8'h00, 16'hFFFF, 8'h00, 32'h0,        0, 0, 0, 8'h00, 32'h0));
        rows.push_back(mk(A_GET,  8'hFF, 16'h0000, 8'h00, 32'h0,        0, 0, 0, 8'h00, 32'h0));
        // set after release keeps the key but the handle stays released
        rows.push_back(mk(A_SET,  8'hFF, 16'hFFFF, 8'h00, 32'h80000000, 0, 0, 0, 8'h00, 32'h0));
        rows.push_back(mk(A_GET,  8'hFF, 16'hFFFF, 8'h00, 32'h0,        0, 0, 0, 8'h00, 32'h0));
        foreach (rows[i]) send_word(rows[i]);

        // Random: mostly puts of fresh keys
        for (int n = 0; n < N_RANDOM; n++) begin
            sel = $urandom_range(0, 99);
            w.typed = 0;
            w.res = '{1'b0, 1'b0, 8'h00, 32'h0};
            w.conn = $urandom_range(0, 255);
            w.now = $urandom;
            if (sel < 70) w.act = A_PUT;
            else if (sel < 84) w.act = A_GET;
            else if (sel < 97) w.act = A_SET;
            else w.act = A_NONE;
            if (seen_keys.size() > 0 &&
                ((w.act == A_PUT) ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 9) < 8)))
            begin
                // reuse a key, recent ones more often than old ones
                if ($urandom_range(0, 1))
                    sel = seen_keys.size() - 1 - $urandom_range(0, (seen_keys.size() > 32) ?
                                                                   31 : seen_keys.size() - 1);
                else
                    sel = $urandom_range(0, seen_keys.size() - 1);
                {w.dest, w.id} = seen_keys[sel];
            end else begin
                w.dest = $urandom_range(0, 255);
                w.id = $urandom_range(0, 65535);
            end
            send_word(w);
        end
        start <= 1'b0;

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_errors == 0)
            $display("PASS packet_id_dedup_cache");
        else
            $display("FAIL packet_id_dedup_cache");
        $finish;
    end

    // Watchdog
    initial begin
        #100ms;
        $display("FAIL packet_id_dedup_cache");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pidc_pkg.sv
rtl/pidc_cell.sv
rtl/packet_id_dedup_cache.sv
tb/packet_id_dedup_cache_tb.sv
